### sv/rpa_pkg.sv
package rpa_pkg;

  // Fixed field widths
  localparam int PAGE_W      = 15;
  localparam int ACTION_W    = 3;
  localparam int COUNT_OUT_W = 8;
  localparam int STATUS_W    = 3;

  // Default sizing
  localparam int NUM_PAGES  = 32768;
  localparam int COUNT_BITS = 8;

  // Request codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ADDREF = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_GETREF = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_INIT   = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_STILL_REF = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_MEM    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD_PAGE  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_COUNT = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // latch request, launch memory reads
    logic fire;    // finish request, load result register
    logic sweep;   // one step of the init sweep
    logic clear;   // one step of the post-reset count clear
  } rpa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_valid;   // result register occupied
    logic is_init;     // latched request is init
    logic init_empty;  // no pages to push on init
    logic sweep_last;  // sweep counter at last page
  } rpa_sts_t;

endpackage

### sv/rpa_ctrl.sv
module rpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output rpa_pkg::rpa_cmd_t cmd_o,
  input  rpa_pkg::rpa_sts_t sts_i
);
  import rpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_CLEAR = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   can_fire;

  // Result register free or draining this cycle
  assign can_fire   = !sts_i.out_valid || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_fire) begin
          cmd_o.fire = 1'b1;
          if (sts_i.is_init && !sts_i.init_empty) begin
            state_d = S_SWEEP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Reset starts the count clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/rpa_datapath.sv
module rpa_datapath #(
  parameter int NumPages  = rpa_pkg::NUM_PAGES,
  parameter int CountBits = rpa_pkg::COUNT_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rpa_pkg::PAGE_W-1:0]       cfg_wdata_i,
  input  logic [rpa_pkg::ACTION_W-1:0]     action_i,
  input  logic [rpa_pkg::PAGE_W-1:0]       page_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [rpa_pkg::PAGE_W-1:0]       page_out_o,
  output logic [rpa_pkg::COUNT_OUT_W-1:0]  ref_count_o,
  output logic [rpa_pkg::STATUS_W-1:0]     status_o,
  input  rpa_pkg::rpa_cmd_t                cmd_i,
  output rpa_pkg::rpa_sts_t                sts_o
);
  import rpa_pkg::*;

  localparam int IdxW = $clog2(NumPages);
  localparam int TopW = $clog2(NumPages + 1);

  // Configuration register
  logic [PAGE_W-1:0] ffp_q;

  // Latched request
  logic [ACTION_W-1:0] act_q;
  logic [PAGE_W-1:0]   pg_q;

  // Stack pointer and sweep counter
  logic [TopW-1:0] top_q, top_d, top_m1;
  logic [IdxW-1:0] swp_q;

  // Memories and registered read data
  logic [CountBits-1:0] ref_mem [NumPages];
  logic [PAGE_W-1:0]    stk_mem [NumPages];
  logic [CountBits-1:0] rd_cnt_q;
  logic [PAGE_W-1:0]    rd_stk_q;

  // Write ports
  logic                 ref_we, stk_we;
  logic [IdxW-1:0]      ref_wa, stk_wa;
  logic [CountBits-1:0] ref_wd;
  logic [PAGE_W-1:0]    stk_wd;

  // Request evaluation
  logic                 ex_ref_we, ex_stk_we;
  logic [IdxW-1:0]      ex_ref_wa;
  logic [CountBits-1:0] ex_ref_wd, ex_cnt, cnt_m1, cnt_p1;
  logic [PAGE_W-1:0]    ex_page;
  logic [STATUS_W-1:0]  ex_stat;
  logic [TopW-1:0]      ex_top;
  logic                 pg_valid, stk_full;

  // Result register
  logic                   out_valid_q;
  logic [PAGE_W-1:0]      page_out_q;
  logic [COUNT_OUT_W-1:0] ref_count_q;
  logic [STATUS_W-1:0]    status_q;

  assign top_m1   = top_q - 1'b1;
  assign pg_valid = (pg_q >= ffp_q) && (32'(pg_q) < NumPages);
  assign stk_full = (32'(top_q) >= NumPages);
  assign cnt_m1   = rd_cnt_q - 1'b1;
  assign cnt_p1   = rd_cnt_q + 1'b1;

  // Evaluate the latched request against the read data
  always_comb begin
    ex_page   = pg_q;
    ex_cnt    = '0;
    ex_stat   = STAT_OK;
    ex_ref_we = 1'b0;
    ex_ref_wa = IdxW'(pg_q);
    ex_ref_wd = '0;
    ex_stk_we = 1'b0;
    ex_top    = top_q;
    case (act_q)
      ACT_ALLOC: begin
        if (top_q == '0) begin
          ex_page = '0;
          ex_stat = STAT_NO_MEM;
        end else begin
          ex_top    = top_m1;
          ex_page   = rd_stk_q;
          ex_cnt    = CountBits'(1);
          ex_ref_we = (32'(rd_stk_q) < NumPages);
          ex_ref_wa = IdxW'(rd_stk_q);
          ex_ref_wd = CountBits'(1);
        end
      end
      ACT_FREE: begin
        if (!pg_valid) begin
          ex_stat = STAT_BAD_PAGE;
        end else if (rd_cnt_q == '0) begin
          ex_stat = STAT_BAD_COUNT;
        end else begin
          ex_ref_we = 1'b1;
          ex_ref_wd = cnt_m1;
          ex_cnt    = cnt_m1;
          if (cnt_m1 != '0) begin
            ex_stat = STAT_STILL_REF;
          end else if (!stk_full) begin
            // last reference gone: page goes back on the stack if it is not full
            ex_stk_we = 1'b1;
            ex_top    = top_q + 1'b1;
          end
        end
      end
      ACT_ADDREF: begin
        if (!pg_valid) begin
          ex_stat = STAT_BAD_PAGE;
        end else if (rd_cnt_q == '1) begin
          ex_cnt  = rd_cnt_q;
          ex_stat = STAT_BAD_COUNT;
        end else begin
          ex_ref_we = 1'b1;
          ex_ref_wd = cnt_p1;
          ex_cnt    = cnt_p1;
        end
      end
      ACT_GETREF: begin
        if (!pg_valid) begin
          ex_stat = STAT_BAD_PAGE;
        end else begin
          ex_cnt = rd_cnt_q;
        end
      end
      ACT_INIT: begin
        ex_top = '0;
      end
      default: begin
        ex_stat = STAT_BAD_PAGE;
      end
    endcase
  end

  // Memory write port selection
  always_comb begin
    ref_we = 1'b0;
    ref_wa = ex_ref_wa;
    ref_wd = ex_ref_wd;
    stk_we = 1'b0;
    stk_wa = top_q[IdxW-1:0];
    stk_wd = pg_q;
    top_d  = top_q;
    if (cmd_i.fire) begin
      ref_we = ex_ref_we;
      stk_we = ex_stk_we;
      top_d  = ex_top;
    end else if (cmd_i.sweep) begin
      ref_we = 1'b1;
      ref_wa = swp_q;
      ref_wd = '0;
      stk_we = 1'b1;
      stk_wd = PAGE_W'(swp_q);
      top_d  = top_q + 1'b1;
    end else if (cmd_i.clear) begin
      ref_we = 1'b1;
      ref_wa = swp_q;
      ref_wd = '0;
    end
  end

  // Reference count memory
  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end
    if (cmd_i.accept) begin
      rd_cnt_q <= ref_mem[IdxW'(page_i)];
    end
  end

  // Free page stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (cmd_i.accept) begin
      rd_stk_q <= stk_mem[top_m1[IdxW-1:0]];
    end
  end

  // Request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= action_i;
      pg_q  <= page_i;
    end
  end

  // Control registers: config, stack pointer, sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ffp_q <= '0;
      top_q <= '0;
      swp_q <= '0;
    end else begin
      if (cfg_we_i) begin
        ffp_q <= cfg_wdata_i;
      end
      top_q <= top_d;
      if (cmd_i.fire && (act_q == ACT_INIT)) begin
        swp_q <= IdxW'(ffp_q);
      end else if (cmd_i.sweep || cmd_i.clear) begin
        swp_q <= swp_q + 1'b1;
      end
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.fire) begin
      page_out_q  <= ex_page;
      ref_count_q <= COUNT_OUT_W'(ex_cnt);
      status_q    <= ex_stat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign page_out_o  = page_out_q;
  assign ref_count_o = ref_count_q;
  assign status_o    = status_q;

  assign sts_o.out_valid  = out_valid_q;
  assign sts_o.is_init    = (act_q == ACT_INIT);
  assign sts_o.init_empty = (32'(ffp_q) >= NumPages);
  assign sts_o.sweep_last = (swp_q == IdxW'(NumPages - 1));

endmodule

### sv/refcounted_page_allocator_top.sv
// Reference-counted page allocator.
// Requests (action, page) arrive on a valid/ready channel; each request
// yields exactly one result (page_out, ref_count, status) on a second
// valid/ready channel. Actions: alloc, free, addref, getref, init.
// first_free_page is written through cfg_we_i/cfg_wdata_i; the user must write it
// only while idle, as the block itself does not enforce this. Timing: a request
// is taken, its count and stack-top entries are read from on-chip memory into
// registers, and once the result register is free the result is registered from
// that read data; a new request is taken only after the previous one completes.
// This comes from the registered count and stack memory reads plus the write-back.
// Init pushes pages first_free_page to NumPages - 1 in a sweep (one page pushed
// per cycle) after its result is posted; no request is taken during the sweep.
// Reset: the stack is emptied and a clearing pass zeroes all NumPages
// reference counts, one per cycle; in_ready_o stays low until the pass ends.
// Stall: the result register holds until out_ready_i; a new request can be
// taken while a result waits, but it completes only once the register frees.
module refcounted_page_allocator_top #(
  parameter int NumPages  = rpa_pkg::NUM_PAGES,
  parameter int CountBits = rpa_pkg::COUNT_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rpa_pkg::PAGE_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rpa_pkg::ACTION_W-1:0]    action_i,
  input  logic [rpa_pkg::PAGE_W-1:0]      page_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rpa_pkg::PAGE_W-1:0]      page_out_o,
  output logic [rpa_pkg::COUNT_OUT_W-1:0] ref_count_o,
  output logic [rpa_pkg::STATUS_W-1:0]    status_o
);
  import rpa_pkg::*;

  rpa_cmd_t cmd;
  rpa_sts_t sts;

  // Sequencer
  rpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Memories, stack pointer and result register
  rpa_datapath #(
    .NumPages  (NumPages),
    .CountBits (CountBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (action_i),
    .page_i      (page_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .page_out_o  (page_out_o),
    .ref_count_o (ref_count_o),
    .status_o    (status_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

### sv/rpa_checker.sv
module rpa_assertions (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [rpa_pkg::PAGE_W-1:0]      page_out_o,
  input logic [rpa_pkg::COUNT_OUT_W-1:0] ref_count_o,
  input logic [rpa_pkg::STATUS_W-1:0]    status_o
);
  import rpa_pkg::*;

  // Stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(page_out_o)
      && $stable(ref_count_o) && $stable(status_o))
    else $error("stalled result changed");

  // One request in flight: no acceptance right after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken back to back");

  // Out of memory reports page 0 and count 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_NO_MEM) |-> (page_out_o == '0) && (ref_count_o == '0))
    else $error("out of memory result not zeroed");

  // Bad page reports count 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_BAD_PAGE) |-> (ref_count_o == '0))
    else $error("bad page result carries a count");

  // Only defined status codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_OK) || (status_o == STAT_STILL_REF)
      || (status_o == STAT_NO_MEM) || (status_o == STAT_BAD_PAGE)
      || (status_o == STAT_BAD_COUNT))
    else $error("undefined status code");

endmodule

bind refcounted_page_allocator_top rpa_assertions u_rpa_assertions (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .page_out_o  (page_out_o),
  .ref_count_o (ref_count_o),
  .status_o    (status_o)
);

### sim/rpa_checker.sv
`timescale 1ns / 100ps

// Watches the request and reply channels of the page allocator, tracks the
// free stack and the reference counts, and scores each reply against the
// oldest outstanding prediction.
module rpa_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rpa_pkg::PAGE_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [rpa_pkg::ACTION_W-1:0]    action_i,
  input  logic [rpa_pkg::PAGE_W-1:0]      page_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [rpa_pkg::PAGE_W-1:0]      page_out_i,
  input  logic [rpa_pkg::COUNT_OUT_W-1:0] ref_count_i,
  input  logic [rpa_pkg::STATUS_W-1:0]    status_i,
  output int                              pending_o,
  output int                              errors_o
);
  import rpa_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [ACTION_W-1:0]    action;
    logic [PAGE_W-1:0]      page;
    logic [PAGE_W-1:0]      page_out;
    logic [COUNT_OUT_W-1:0] ref_count;
    logic [STATUS_W-1:0]    status;
  } page_reply_t;

  // Shadow allocator state
  logic [COUNT_BITS-1:0] ref_counts [NUM_PAGES];
  logic [PAGE_W-1:0]     free_pages [NUM_PAGES];
  int unsigned           free_depth;
  logic [PAGE_W-1:0]     base_page;

  page_reply_t reply_q [$];
  int          mismatches;

  function automatic bit page_owned(logic [PAGE_W-1:0] p);
    return p >= base_page && int'(p) < NUM_PAGES;
  endfunction

  // Push onto the free stack; a push onto a full stack is dropped
  function automatic void release_page(logic [PAGE_W-1:0] p);
    if (free_depth < NUM_PAGES) begin
      free_pages[free_depth] = p;
      free_depth++;
    end
  endfunction

  // Apply one request to the shadow state and return its reply
  function automatic page_reply_t predict_reply(logic [ACTION_W-1:0] action,
                                                logic [PAGE_W-1:0] page);
    page_reply_t r;
    r.action    = action;
    r.page      = page;
    r.page_out  = page;
    r.ref_count = '0;
    r.status    = STAT_OK;
    case (action)
      ACT_ALLOC: begin
        if (free_depth == 0) begin
          r.page_out = '0;
          r.status   = STAT_NO_MEM;
        end else begin
          free_depth--;
          r.page_out             = free_pages[free_depth];
          ref_counts[r.page_out] = COUNT_BITS'(1);
          r.ref_count            = COUNT_OUT_W'(1);
        end
      end
      ACT_FREE: begin
        if (!page_owned(page)) begin
          r.status = STAT_BAD_PAGE;
        end else if (ref_counts[page] == '0) begin
          r.status = STAT_BAD_COUNT;
        end else begin
          ref_counts[page]--;
          r.ref_count = COUNT_OUT_W'(ref_counts[page]);
          if (ref_counts[page] != '0) begin
            r.status = STAT_STILL_REF;
          end else begin
            release_page(page);
          end
        end
      end
      ACT_ADDREF: begin
        if (!page_owned(page)) begin
          r.status = STAT_BAD_PAGE;
        end else if (ref_counts[page] == '1) begin
          // saturated: count held
          r.ref_count = COUNT_OUT_W'(ref_counts[page]);
          r.status    = STAT_BAD_COUNT;
        end else begin
          ref_counts[page]++;
          r.ref_count = COUNT_OUT_W'(ref_counts[page]);
        end
      end
      ACT_GETREF: begin
        if (!page_owned(page)) begin
          r.status = STAT_BAD_PAGE;
        end else begin
          r.ref_count = COUNT_OUT_W'(ref_counts[page]);
        end
      end
      ACT_INIT: begin
        // rebuild the stack, highest page ends on top
        free_depth = 0;
        for (int p = int'(base_page); p < NUM_PAGES; p++) begin
          ref_counts[p] = '0;
          release_page(PAGE_W'(p));
        end
      end
      default: begin
        r.status = STAT_BAD_PAGE;
      end
    endcase
    return r;
  endfunction

  // Sample every transaction at the clock edge that completes it
  always @(posedge clk_i or negedge rst_ni) begin
    page_reply_t want;
    if (!rst_ni) begin
      base_page  = '0;
      free_depth = 0;
      mismatches = 0;
      reply_q.delete();
      for (int p = 0; p < NUM_PAGES; p++) begin
        ref_counts[p] = '0;
        free_pages[p] = '0;
      end
    end else begin
      if (cfg_we_i) begin
        base_page = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: unexpected reply page %0d count %0d status %0d",
                     $realtime, page_out_i, ref_count_i, status_i);
          end
        end else begin
          want = reply_q.pop_front();
          if (page_out_i !== want.page_out || ref_count_i !== want.ref_count ||
              status_i !== want.status) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("%0t: action %0d page %0d: expected page %0d count %0d status %0d,",
                       $realtime, want.action, want.page, want.page_out,
                       want.ref_count, want.status);
              $display("    got page %0d count %0d status %0d",
                       page_out_i, ref_count_i, status_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        reply_q.push_back(predict_reply(action_i, page_i));
      end
    end
    pending_o <= reply_q.size();
    errors_o  <= mismatches;
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rpa_pkg::*;

  localparam int IdleLimit  = 200000;
  localparam int SettleWait = 8;
  localparam int WindowSize = 64;
  localparam int InitWindow = 4096;

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [PAGE_W-1:0]      cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [ACTION_W-1:0]    action_i    = ACT_GETREF;
  logic [PAGE_W-1:0]      page_i      = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b1;
  logic [PAGE_W-1:0]      page_out_o;
  logic [COUNT_OUT_W-1:0] ref_count_o;
  logic [STATUS_W-1:0]    status_o;

  int          pending;
  int          fail_count;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic [PAGE_W-1:0] base_cur = '0;
  bit          last_was_init = 1'b0;
  int          idle_cycles   = 0;

  refcounted_page_allocator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .page_i      (page_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .page_out_o  (page_out_o),
    .ref_count_o (ref_count_o),
    .status_o    (status_o)
  );

  rpa_checker reply_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .action_i    (action_i),
    .page_i      (page_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .page_out_i  (page_out_o),
    .ref_count_i (ref_count_o),
    .status_i    (status_o),
    .pending_o   (pending),
    .errors_o    (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reply side backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Watchdog: cycles without any transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // One request transaction, with random idle cycles ahead of it
  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [PAGE_W-1:0] pg);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    page_i        <= pg;
    last_was_init = (act == ACT_INIT);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Hold off until all replies are in; an init may still be sweeping
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (last_was_init ? NUM_PAGES - int'(base_cur) + SettleWait : SettleWait)
      @(posedge clk_i);
  endtask

  task automatic write_base(input logic [PAGE_W-1:0] value);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    base_cur    = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly pages in a small window at the top of the owned range
  function automatic logic [PAGE_W-1:0] pick_page();
    int unsigned r;
    int          lo;
    r  = $urandom_range(0, 99);
    lo = (int'(base_cur) > NUM_PAGES - WindowSize) ? int'(base_cur) : NUM_PAGES - WindowSize;
    if (r < 85) return PAGE_W'($urandom_range(lo, NUM_PAGES - 1));
    else if (r < 95) return PAGE_W'($urandom_range(0, NUM_PAGES - 1));
    else if (r < 97) return '0;
    else if (r < 98) return '1;
    else return base_cur - 1'b1;
  endfunction

  // Init only where the sweep is short
  function automatic logic [ACTION_W-1:0] pick_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return ACT_ALLOC;
    else if (r < 60) return ACT_FREE;
    else if (r < 75) return ACT_ADDREF;
    else if (r < 88) return ACT_GETREF;
    else if (r < 90)
      return (int'(base_cur) >= NUM_PAGES - InitWindow) ? ACT_INIT : ACT_ALLOC;
    else if (r < 97) return ACT_ALLOC;
    else return ACTION_W'($urandom_range(int'(ACT_INIT) + 1, (1 << ACTION_W) - 1));
  endfunction

  task automatic run_phase(input logic [PAGE_W-1:0] base, input int unsigned tx,
                           input int unsigned rx, input int count, input bit with_init);
    write_base(base);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    if (with_init) send_request(ACT_INIT, pick_page());
    repeat (count) send_request(pick_action(), pick_page());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset base of zero, empty stack
    send_request(ACT_ALLOC, '1);
    send_request(ACT_GETREF, '0);
    send_request(ACT_FREE, '0);
    send_request(ACT_ADDREF, '1);
    send_request(ACT_FREE, '1);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_FREE, '1);
    send_request(ACT_INIT + 3'd1, '0);
    send_request(ACT_INIT + 3'd2, '1);
    send_request(ACT_INIT + 3'd3, 15'h2AAA);

    // Directed: small owned range, out of range pages, drain to empty
    write_base(15'd32760);
    send_request(ACT_INIT, 15'h5555);
    send_request(ACT_GETREF, 15'd32759);
    send_request(ACT_FREE, '0);
    send_request(ACT_ADDREF, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ADDREF, '1);
    send_request(ACT_FREE, '1);
    send_request(ACT_FREE, '1);
    repeat (9) send_request(ACT_ALLOC, '0);

    run_phase(15'd32704, 0, 0, 150, 1'b1);
    run_phase('1, 71, 0, 150, 1'b1);
    run_phase(15'd32740, 0, 71, 200, 1'b1);

    // Whole memory owned: full stack drops a push, count saturates
    write_base('0);
    tx_idle_pct  = 26;
    rx_stall_pct = 26;
    send_request(ACT_INIT, pick_page());
    send_request(ACT_ADDREF, 15'd5);
    send_request(ACT_FREE, 15'd5);
    repeat (258) send_request(ACT_ADDREF, 15'd100);
    repeat (4) send_request(ACT_FREE, 15'd100);
    repeat (150) send_request(pick_action(), pick_page());

    // Raise the base over a stack that still holds low pages
    run_phase(15'd32720, 0, 0, 150, 1'b0);
    run_phase(15'd32720, 26, 26, 150, 1'b1);

    quiesce();
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
